/* rtl/tema_pkg.sv */
// shared constants and types of the triple average tracker bank
package tema_pkg;

   localparam int FIELD_BITS     = 20;
   localparam int QTY_BITS       = 2;
   localparam int QUANTITIES     = 4;
   localparam int DECAY_BITS     = 12;
   localparam int CSR_INDEX_BITS = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_SHORT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_MID   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DECAY_LONG  = 2'd2;

   // decay values after reset, before clamping to one
   localparam logic [DECAY_BITS-1:0] DECAY_SHORT_RESET = 12'd1884;
   localparam logic [DECAY_BITS-1:0] DECAY_MID_RESET   = 12'd2014;
   localparam logic [DECAY_BITS-1:0] DECAY_LONG_RESET  = 12'd2037;

   // effective decay factors, already clamped to one
   typedef struct packed {
      logic [DECAY_BITS-1:0] d_short;
      logic [DECAY_BITS-1:0] d_mid;
      logic [DECAY_BITS-1:0] d_long;
   } decay_set_type;

endpackage

/* rtl/tema_cfg_regs.sv */
// decay factor registers, stored clamped to one
module tema_cfg_regs #(
   parameter int FRAC_BITS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tema_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tema_pkg::DECAY_BITS-1:0]     csr_wdata,
   output tema_pkg::decay_set_type             decay
);
   import tema_pkg::*;

   localparam logic [DECAY_BITS-1:0] ONE = DECAY_BITS'(1 << FRAC_BITS);

   function automatic logic [DECAY_BITS-1:0] clamp_one(input logic [DECAY_BITS-1:0] v);
      return (v > ONE) ? ONE : v;
   endfunction

   decay_set_type decay_ff;
   decay_set_type decay_in;

   always_comb begin
      decay_in = decay_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DECAY_SHORT: decay_in.d_short = clamp_one(csr_wdata);
            REG_DECAY_MID:   decay_in.d_mid   = clamp_one(csr_wdata);
            REG_DECAY_LONG:  decay_in.d_long  = clamp_one(csr_wdata);
            default:         decay_in = decay_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff.d_short <= clamp_one(DECAY_SHORT_RESET);
         decay_ff.d_mid   <= clamp_one(DECAY_MID_RESET);
         decay_ff.d_long  <= clamp_one(DECAY_LONG_RESET);
      end else begin
         decay_ff <= decay_in;
      end
   end

   assign decay = decay_ff;

endmodule

/* rtl/tema_blend.sv */
// one exponential average update: sample + ((avg - sample) * decay) >> frac
module tema_blend #(
   parameter int SAMPLE_BITS = 20,
   parameter int FRAC_BITS   = 11
) (
   input  logic [SAMPLE_BITS-1:0]          avg,
   input  logic [SAMPLE_BITS-1:0]          sample,
   input  logic [tema_pkg::DECAY_BITS-1:0] decay,
   output logic [SAMPLE_BITS-1:0]          blended
);
   import tema_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + DECAY_BITS + 2;

   logic signed [SAMPLE_BITS:0]   diff;
   logic signed [DECAY_BITS:0]    decay_s;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [PROD_BITS-1:0]   scaled;

   always_comb begin
      diff    = $signed({1'b0, avg}) - $signed({1'b0, sample});
      decay_s = $signed({1'b0, decay});
      prod    = diff * decay_s;
      // arithmetic shift floors, matching truncation of the unsigned form
      scaled  = prod >>> FRAC_BITS;
      blended = sample + scaled[SAMPLE_BITS-1:0];
   end

endmodule

/* rtl/tema_state_mem.sv */
// tracker average store, one write and one registered read port
module tema_state_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 60
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   // read returns the contents before a same-edge write
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/triple_ema_tracker_bank_unit.sv */
// top level of the triple exponential average tracker bank
//
//  channel  direction  fields (lowest bit first)
//  req_*    in         channel, quantity, sample
//  rsp_*    out        out_channel, out_quantity, latest, avg_short, avg_mid, avg_long
//  csr_*    in         write enable, register index, write data (decay factors)
//
// one item per cycle while rsp is taken, also back-to-back on the same tracker
// rsp_tvalid rises after the req transfer once the item has passed the blend stage
// register (memory read on the transfer edge) and entered the response register;
// the state memory has one read and one write port; the last written tracker
// is forwarded past the memory to cover the read that overlaps its write
// synchronous reset clears all seen bits directly, no clearing pass
// a stalled rsp holds the blend stage, req_tready falls only when both are full
module triple_ema_tracker_bank_unit #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 20,
   parameter int FRAC_BITS   = 11,
   localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int REQ_BITS   = CH_BITS + tema_pkg::QTY_BITS + tema_pkg::FIELD_BITS,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = CH_BITS + tema_pkg::QTY_BITS + 4 * tema_pkg::FIELD_BITS,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_W-1:0]                    req_tdata,  // channel, quantity, sample
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_W-1:0]                    rsp_tdata,  // out_channel, out_quantity,
                                                           // latest, avg_short, avg_mid,
                                                           // avg_long
   // decay factor writes
   input  logic                                csr_we,
   input  logic [tema_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tema_pkg::DECAY_BITS-1:0]     csr_wdata
);
   import tema_pkg::*;

   localparam int TRACKERS  = CHANNELS * QUANTITIES;
   localparam int ADDR_BITS = $clog2(TRACKERS);
   localparam int MEM_W     = 3 * SAMPLE_BITS;
   localparam logic [CH_BITS:0] CH_LIMIT = (CH_BITS + 1)'(CHANNELS);

   // request field unpacking
   logic [CH_BITS-1:0]     req_ch;
   logic [QTY_BITS-1:0]    req_qty;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic                   req_xfer;
   logic                   req_in_range;
   logic [ADDR_BITS-1:0]   req_idx;

   assign req_ch       = req_tdata[CH_BITS-1:0];
   assign req_qty      = req_tdata[CH_BITS +: QTY_BITS];
   // only the low sample bits are kept
   assign req_sample   = req_tdata[CH_BITS + QTY_BITS +: SAMPLE_BITS];
   assign req_xfer     = req_tvalid && req_tready;
   assign req_in_range = ({1'b0, req_ch} < CH_LIMIT);
   assign req_idx      = ADDR_BITS'({req_ch, req_qty});

   decay_set_type decay;

   tema_cfg_regs #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .decay     (decay)
   );

   // blend stage registers (item waiting on its memory read)
   logic                   s1_valid_ff, s1_valid_in;
   logic [CH_BITS-1:0]     s1_ch_ff;
   logic [QTY_BITS-1:0]    s1_qty_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [ADDR_BITS-1:0]   s1_idx_ff;

   // response register, its averages double as the forwarding copy
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CH_BITS-1:0]     rsp_ch_ff;
   logic [QTY_BITS-1:0]    rsp_qty_ff;
   logic [SAMPLE_BITS-1:0] rsp_latest_ff;
   logic [SAMPLE_BITS-1:0] rsp_short_ff, rsp_mid_ff, rsp_long_ff;

   // last written tracker
   logic                   wb_valid_ff, wb_valid_in;
   logic [ADDR_BITS-1:0]   wb_idx_ff;

   logic [TRACKERS-1:0]    seen_ff, seen_in;

   logic                   out_free;
   logic                   s1_adv;
   logic                   s1_seen;
   logic                   wb_hit;
   logic [MEM_W-1:0]       mem_rdata;
   logic [SAMPLE_BITS-1:0] old_short, old_mid, old_long;
   logic [SAMPLE_BITS-1:0] new_short, new_mid, new_long;
   logic [SAMPLE_BITS-1:0] res_short, res_mid, res_long;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   tema_state_mem #(
      .DEPTH (TRACKERS),
      .WIDTH (MEM_W)
   ) u_mem (
      .clock (clock),
      .we    (s1_adv),
      .waddr (s1_idx_ff),
      .wdata ({res_long, res_mid, res_short}),
      .re    (req_xfer),
      .raddr (req_idx),
      .rdata (mem_rdata)
   );

   // forward the write that landed on the same edge as this item's read
   assign s1_seen = seen_ff[s1_idx_ff];
   assign wb_hit  = wb_valid_ff && (wb_idx_ff == s1_idx_ff);

   always_comb begin
      if (wb_hit) begin
         old_short = rsp_short_ff;
         old_mid   = rsp_mid_ff;
         old_long  = rsp_long_ff;
      end else begin
         old_short = mem_rdata[0 +: SAMPLE_BITS];
         old_mid   = mem_rdata[SAMPLE_BITS +: SAMPLE_BITS];
         old_long  = mem_rdata[2 * SAMPLE_BITS +: SAMPLE_BITS];
      end
   end

   tema_blend #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_blend_short (
      .avg (old_short), .sample (s1_sample_ff), .decay (decay.d_short), .blended (new_short)
   );
   tema_blend #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_blend_mid (
      .avg (old_mid), .sample (s1_sample_ff), .decay (decay.d_mid), .blended (new_mid)
   );
   tema_blend #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_blend_long (
      .avg (old_long), .sample (s1_sample_ff), .decay (decay.d_long), .blended (new_long)
   );

   // first sample of a tracker seeds all three averages
   always_comb begin
      if (s1_seen) begin
         res_short = new_short;
         res_mid   = new_mid;
         res_long  = new_long;
      end else begin
         res_short = s1_sample_ff;
         res_mid   = s1_sample_ff;
         res_long  = s1_sample_ff;
      end
   end

   // control next values
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      wb_valid_in  = wb_valid_ff;
      seen_in      = seen_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s1_valid_in        = 1'b0;
         rsp_valid_in       = 1'b1;
         wb_valid_in        = 1'b1;
         seen_in[s1_idx_ff] = 1'b1;
      end
      // out-of-range channels are taken and dropped
      if (req_xfer) begin
         s1_valid_in = req_in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wb_valid_ff  <= 1'b0;
         seen_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wb_valid_ff  <= wb_valid_in;
         seen_ff      <= seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ch_ff     <= req_ch;
         s1_qty_ff    <= req_qty;
         s1_sample_ff <= req_sample;
         s1_idx_ff    <= req_idx;
      end
      if (s1_adv) begin
         rsp_ch_ff     <= s1_ch_ff;
         rsp_qty_ff    <= s1_qty_ff;
         rsp_latest_ff <= s1_sample_ff;
         rsp_short_ff  <= res_short;
         rsp_mid_ff    <= res_mid;
         rsp_long_ff   <= res_long;
         wb_idx_ff     <= s1_idx_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({FIELD_BITS'(rsp_long_ff),
                               FIELD_BITS'(rsp_mid_ff),
                               FIELD_BITS'(rsp_short_ff),
                               FIELD_BITS'(rsp_latest_ff),
                               rsp_qty_ff,
                               rsp_ch_ff});

`ifndef SYNTHESIS
   // a fresh tracker reports its sample as every average
   a_seed_avgs: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !s1_seen) |=>
         (rsp_short_ff == rsp_latest_ff) && (rsp_mid_ff == rsp_latest_ff) &&
         (rsp_long_ff == rsp_latest_ff))
      else $error("unseen tracker did not seed its averages");

   // seen bits are never cleared outside reset
   a_seen_grow: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(seen_ff) & ~seen_ff) == '0))
      else $error("seen bit cleared without reset");

   // a written tracker is marked seen afterwards
   a_seen_set: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> seen_ff[$past(s1_idx_ff)])
      else $error("updated tracker not marked seen");

   // a new response only follows an occupied blend stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s1_valid_ff))
      else $error("response appeared without a blend stage item");
`endif

endmodule

/* tb/triple_ema_tracker_bank_unit_tb.sv */
// self-checking stream testbench for the triple average tracker bank
module triple_ema_tracker_bank_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tema_pkg::*;

   // fixed-point scale of the decay factors: one is 2048
   localparam int          FRAC_BITS    = 11;
   localparam logic [11:0] DECAY_ONE    = 12'd2048;
   localparam int          TRACKERS     = 8;
   localparam int          SETTLE_WAIT  = 8;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          RANDOM_ITEMS = 147;     // per phase, eight phases
   localparam int          PHASES       = 8;
   localparam int          SHOW_LIMIT   = 10;

   typedef struct packed {
      logic                  channel;
      logic [QTY_BITS-1:0]   quantity;
      logic [FIELD_BITS-1:0] sample;
   } sample_item_type;

   typedef struct packed {
      logic                  channel;
      logic [QTY_BITS-1:0]   quantity;
      logic [FIELD_BITS-1:0] latest;
      logic [FIELD_BITS-1:0] avg_short;
      logic [FIELD_BITS-1:0] avg_mid;
      logic [FIELD_BITS-1:0] avg_long;
   } reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;   // channel, quantity, sample, zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [87:0]           rsp_tdata;        // out_channel, out_quantity, latest,
                                            // avg_short, avg_mid, avg_long, zero pad
   logic                  csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_DECAY_SHORT;
   logic [DECAY_BITS-1:0] csr_wdata = '0;

   // samples waiting to be offered, and readings the block still owes us
   sample_item_type sample_q[$];
   reading_type     reading_q[$];

   // our own copy of the decay registers and the tracker bank
   logic [DECAY_BITS-1:0] dec_short = DECAY_SHORT_RESET;
   logic [DECAY_BITS-1:0] dec_mid   = DECAY_MID_RESET;
   logic [DECAY_BITS-1:0] dec_long  = DECAY_LONG_RESET;
   logic                  trk_seen   [TRACKERS];
   logic [FIELD_BITS-1:0] trk_latest [TRACKERS];
   logic [FIELD_BITS-1:0] trk_short  [TRACKERS];
   logic [FIELD_BITS-1:0] trk_mid    [TRACKERS];
   logic [FIELD_BITS-1:0] trk_long   [TRACKERS];

   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   int  mismatch_count = 0;
   int  cycle_count   = 0;
   bit  req_done      = 1'b0;   // a req transfer happened at the last rising edge

   triple_ema_tracker_bank_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // one blend step of an exponential average, decay above one acts as one
   function automatic logic [FIELD_BITS-1:0] blend_average(
      input logic [FIELD_BITS-1:0] avg,
      input logic [DECAY_BITS-1:0] decay,
      input logic [FIELD_BITS-1:0] smp
   );
      logic [DECAY_BITS-1:0] d;
      logic [33:0]           acc;
      d   = (decay > DECAY_ONE) ? DECAY_ONE : decay;
      acc = 34'(avg) * 34'(d) + 34'(smp) * 34'(DECAY_ONE - d);
      return acc[FRAC_BITS +: FIELD_BITS];
   endfunction

   // request driver: offers the next sample at the falling edge once the last one is taken
   always @(negedge clock) begin : req_driver
      sample_item_type it;
      if (!reset && (!req_tvalid || req_done)) begin
         if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            it = sample_q.pop_front();
            req_tdata  <= {1'b0, it.sample, it.quantity, it.channel};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response back-pressure, random per cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: predicts on each req transfer, checks each rsp transfer
   always @(posedge clock) begin : monitor
      sample_item_type rq;
      reading_type     want, got;
      logic [2:0]      t;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         req_done = req_tvalid && req_tready;
         if (!reset && req_done) begin
            rq.channel  = req_tdata[0];
            rq.quantity = req_tdata[2:1];
            rq.sample   = req_tdata[22:3];
            t = {rq.channel, rq.quantity};
            // first sample of a tracker loads all three averages
            if (!trk_seen[t]) begin
               trk_seen[t]  = 1'b1;
               trk_short[t] = rq.sample;
               trk_mid[t]   = rq.sample;
               trk_long[t]  = rq.sample;
            end else begin
               trk_short[t] = blend_average(trk_short[t], dec_short, rq.sample);
               trk_mid[t]   = blend_average(trk_mid[t],   dec_mid,   rq.sample);
               trk_long[t]  = blend_average(trk_long[t],  dec_long,  rq.sample);
            end
            trk_latest[t]  = rq.sample;
            want.channel   = rq.channel;
            want.quantity  = rq.quantity;
            want.latest    = trk_latest[t];
            want.avg_short = trk_short[t];
            want.avg_mid   = trk_mid[t];
            want.avg_long  = trk_long[t];
            reading_q.push_back(want);
         end
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.channel   = rsp_tdata[0];
            got.quantity  = rsp_tdata[2:1];
            got.latest    = rsp_tdata[22:3];
            got.avg_short = rsp_tdata[42:23];
            got.avg_mid   = rsp_tdata[62:43];
            got.avg_long  = rsp_tdata[82:63];
            if (reading_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_LIMIT)
                  $display("unexpected rsp transfer at cycle %0d: %p", cycle_count, got);
            end else begin
               want = reading_q.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOW_LIMIT) begin
                     $display("mismatch at cycle %0d", cycle_count);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
               end
            end
         end
      end
   end

   // register write while the block is idle, mirrored into our copy
   task automatic write_decay(input logic [CSR_INDEX_BITS-1:0] idx,
                              input logic [DECAY_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_DECAY_SHORT: dec_short = value;
         REG_DECAY_MID:   dec_mid   = value;
         REG_DECAY_LONG:  dec_long  = value;
         default: ;
      endcase
   endtask

   // hold off until every sample is through and every reading has arrived
   task automatic wait_until_drained();
      while (sample_q.size() != 0 || req_tvalid || reading_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   initial begin : stimulus
      sample_item_type it;
      logic [2:0]      last_t;
      logic [2:0]      t;
      for (int i = 0; i < TRACKERS; i++) trk_seen[i] = 1'b0;
      last_t = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         // decay settings per phase, extremes and above-one values among them
         case (p)
            1: begin
               write_decay(REG_DECAY_SHORT, 12'd0);
               write_decay(REG_DECAY_MID, 12'd0);
               write_decay(REG_DECAY_LONG, 12'd0);
            end
            2: begin
               write_decay(REG_DECAY_SHORT, DECAY_ONE);
               write_decay(REG_DECAY_MID, DECAY_ONE);
               write_decay(REG_DECAY_LONG, DECAY_ONE);
            end
            3: begin
               // above one, clamped so the average holds
               write_decay(REG_DECAY_SHORT, 12'hFFF);
               write_decay(REG_DECAY_MID, 12'd2049);
               write_decay(REG_DECAY_LONG, 12'd3000);
            end
            4: begin
               write_decay(REG_DECAY_SHORT, 12'd1);
               write_decay(REG_DECAY_MID, 12'd2047);
               write_decay(REG_DECAY_LONG, 12'd1024);
            end
            5: begin
               write_decay(REG_DECAY_SHORT, 12'($urandom_range(4095)));
               write_decay(REG_DECAY_MID, 12'($urandom_range(4095)));
               write_decay(REG_DECAY_LONG, 12'($urandom_range(4095)));
            end
            6: begin
               write_decay(REG_DECAY_SHORT, 12'($urandom_range(2048)));
               write_decay(REG_DECAY_MID, 12'($urandom_range(2048)));
               write_decay(REG_DECAY_LONG, 12'($urandom_range(2048)));
            end
            7: begin
               write_decay(REG_DECAY_SHORT, DECAY_SHORT_RESET);
               write_decay(REG_DECAY_MID, DECAY_MID_RESET);
               write_decay(REG_DECAY_LONG, DECAY_LONG_RESET);
            end
            default: ;
         endcase

         // idling modes: none, sender idle, receiver stalling, both
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 75; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 75; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase

         if (p == 0) begin
            // directed: first sample of every tracker, then the opposite extreme,
            // then a random sample, all with the reset decays
            for (int k = 0; k < 3 * TRACKERS; k++) begin
               t = 3'(k % TRACKERS);
               it.channel  = t[2];
               it.quantity = t[1:0];
               if (k < TRACKERS)
                  it.sample = t[0] ? 20'hFFFFF : 20'h00000;
               else if (k < 2 * TRACKERS)
                  it.sample = t[0] ? 20'h00000 : 20'hFFFFF;
               else
                  it.sample = 20'($urandom);
               sample_q.push_back(it);
            end
         end

         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // often hit the same tracker again to exercise back-to-back updates
            if ($urandom_range(3) == 0)
               t = last_t;
            else
               t = 3'($urandom_range(7));
            last_t      = t;
            it.channel  = t[2];
            it.quantity = t[1:0];
            case ($urandom_range(7))
               0:       it.sample = 20'h00000;
               1:       it.sample = 20'hFFFFF;
               2:       it.sample = 20'($urandom_range(255));
               default: it.sample = 20'($urandom);
            endcase
            sample_q.push_back(it);
            // mid-phase pause until everything outstanding has come back
            if (n == RANDOM_ITEMS / 2 && p == 3)
               wait_until_drained();
         end
         wait_until_drained();
      end

      if (reading_q.size() != 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* triple_ema_tracker_bank_unit.f */
rtl/tema_pkg.sv
rtl/tema_cfg_regs.sv
rtl/tema_blend.sv
rtl/tema_state_mem.sv
rtl/triple_ema_tracker_bank_unit.sv
tb/triple_ema_tracker_bank_unit_tb.sv
